// ----- sv/vsaf_pkg.sv -----
// Package: shared types and constants of the variant site allele filter.
`default_nettype none
package vsaf_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 17;
  localparam int unsigned COV_W     = 16;
  localparam int unsigned FRAC_W    = 17;
  localparam int unsigned IDX_W     = 20;
  localparam int unsigned Q16_BITS  = 16;
  localparam int unsigned FIFO_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_DEPTH         = 2'd0,
    CFG_MIN_ALLELE_FRAC   = 2'd1,
    CFG_MAX_ALLELE_FRAC   = 2'd2,
    CFG_MAX_LOW_QUAL_FRAC = 2'd3
  } cfg_reg_e;

  localparam logic [COV_W-1:0]  MIN_DEPTH_RST         = 16'd5;
  localparam logic [FRAC_W-1:0] MIN_ALLELE_FRAC_RST   = 17'd13107;
  localparam logic [FRAC_W-1:0] MAX_ALLELE_FRAC_RST   = 17'd52429;
  localparam logic [FRAC_W-1:0] MAX_LOW_QUAL_FRAC_RST = 17'd32768;

  // one finished site, handed from the front to the back
  typedef struct packed {
    logic [COV_W-1:0]  depth;
    logic [COV_W-1:0]  low;
    logic [COV_W:0]    lq_sum;
    logic [COV_W-1:0]  top;
    logic [COV_W-1:0]  second;
    logic              chunk_end;
  } site_rec_t;

endpackage
`default_nettype wire

// ----- sv/vsaf_if.sv -----
// Interfaces: allele entry, site result and configuration write channels.
`default_nettype none
interface vsaf_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] site_depth;
  logic [15:0] low_qual_depth;
  logic [15:0] allele_cov;
  logic        is_deletion;
  logic        last_of_site;
  logic        last_of_chunk;
  modport source (output valid, site_depth, low_qual_depth, allele_cov, is_deletion,
                  last_of_site, last_of_chunk, input ready);
  modport sink   (input valid, site_depth, low_qual_depth, allele_cov, is_deletion,
                  last_of_site, last_of_chunk, output ready);
endinterface

interface vsaf_out_if;
  logic        valid;
  logic        ready;
  logic        keep;
  logic [19:0] kept_index;
  logic [15:0] top_cov;
  logic [15:0] second_cov;
  modport source (output valid, keep, kept_index, top_cov, second_cov, input ready);
  modport sink   (input valid, keep, kept_index, top_cov, second_cov, output ready);
endinterface

interface vsaf_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [vsaf_pkg::CFG_IDX_W-1:0]   index;
  logic [vsaf_pkg::CFG_DAT_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- sv/vsaf_front.sv -----
// Front: accepts allele entries, tracks the two top coverages, emits site records.
`default_nettype none
module vsaf_front #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  vsaf_in_if.sink            in_i,
  input  wire logic          full_i,
  output vsaf_pkg::site_rec_t rec_o,
  output logic               push_o
);

  localparam int unsigned CW = (COUNT_BITS < vsaf_pkg::COV_W) ? COUNT_BITS : vsaf_pkg::COV_W;
  localparam logic [vsaf_pkg::COV_W-1:0] CovMask =
    vsaf_pkg::COV_W'((64'd1 << CW) - 64'd1);

  logic [vsaf_pkg::COV_W-1:0] best_q, best_d, second_q, second_d;
  logic [vsaf_pkg::COV_W-1:0] cov, depth, low;
  logic                       accept;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;

  assign cov   = in_i.allele_cov & CovMask;
  assign depth = in_i.site_depth & CovMask;
  assign low   = in_i.low_qual_depth & CovMask;

  always_comb begin
    best_d   = best_q;
    second_d = second_q;
    if (!in_i.is_deletion) begin
      if (cov > best_q) begin
        second_d = best_q;
        best_d   = cov;
      end else if (cov > second_q) begin
        second_d = cov;
      end
    end
  end

  always_comb begin
    rec_o.depth     = depth;
    rec_o.low       = low;
    rec_o.lq_sum    = {1'b0, low} + {1'b0, depth};
    rec_o.top       = best_d;
    rec_o.second    = second_d;
    rec_o.chunk_end = in_i.last_of_chunk;
  end

  assign push_o = accept && in_i.last_of_site;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q   <= '0;
      second_q <= '0;
    end else if (accept) begin
      if (in_i.last_of_site) begin
        best_q   <= '0;
        second_q <= '0;
      end else begin
        best_q   <= best_d;
        second_q <= second_d;
      end
    end
  end

  a_second_le_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    second_q <= best_q)
    else $error("runner-up coverage above top coverage");

endmodule
`default_nettype wire

// ----- sv/vsaf_fifo.sv -----
// Short queue of site records between front and back.
`default_nettype none
module vsaf_fifo (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire vsaf_pkg::site_rec_t rec_i,
  output logic                     full_o,
  input  wire logic                pop_i,
  output logic                     valid_o,
  output vsaf_pkg::site_rec_t      rec_o
);

  localparam int unsigned Depth = vsaf_pkg::FIFO_DEPTH;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  vsaf_pkg::site_rec_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign rec_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count above depth");

  a_no_lost_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("site record pushed into full queue");

endmodule
`default_nettype wire

// ----- sv/vsaf_back.sv -----
// Back: configuration registers, fraction tests, kept counter and result register.
`default_nettype none
module vsaf_back #(
  parameter int unsigned MAX_SITES = 1048576
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  vsaf_cfg_if.sink                 cfg_i,
  input  wire logic                valid_i,
  input  wire vsaf_pkg::site_rec_t rec_i,
  output logic                     pop_o,
  vsaf_out_if.source               out_o
);

  localparam int unsigned KW = $clog2(MAX_SITES + 1);
  localparam int unsigned CW = vsaf_pkg::COV_W;
  localparam int unsigned PW = vsaf_pkg::FRAC_W + CW;       // frac * depth
  localparam int unsigned LW = vsaf_pkg::FRAC_W + CW + 1;   // frac * (low + depth)

  logic [CW-1:0]                min_depth_q;
  logic [vsaf_pkg::FRAC_W-1:0]  min_frac_q, max_frac_q, lq_frac_q;

  // stage 1: products
  logic          s1_valid_q;
  logic [PW-1:0] p_min_q, p_max_q;
  logic [LW-1:0] p_lq_q;
  logic          depth_lt_q, chunk_end_q;
  logic [CW-1:0] low_q, top_q, second_q;

  // result register
  logic                        out_valid_q;
  logic                        keep_q;
  logic [vsaf_pkg::IDX_W-1:0]  idx_q;
  logic [CW-1:0]               otop_q, osecond_q;
  logic [KW-1:0]               kept_cnt_q;

  logic          out_adv, s1_load, lq_fail, top_ok, second_ok, keep;
  logic [KW-1:0] idx_sat;
  logic [PW-1:0] top_sc, second_sc;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_depth_q <= vsaf_pkg::MIN_DEPTH_RST;
      min_frac_q  <= vsaf_pkg::MIN_ALLELE_FRAC_RST;
      max_frac_q  <= vsaf_pkg::MAX_ALLELE_FRAC_RST;
      lq_frac_q   <= vsaf_pkg::MAX_LOW_QUAL_FRAC_RST;
    end else if (cfg_i.valid) begin
      unique case (vsaf_pkg::cfg_reg_e'(cfg_i.index))
        vsaf_pkg::CFG_MIN_DEPTH:         min_depth_q <= cfg_i.data[CW-1:0];
        vsaf_pkg::CFG_MIN_ALLELE_FRAC:   min_frac_q  <= cfg_i.data;
        vsaf_pkg::CFG_MAX_ALLELE_FRAC:   max_frac_q  <= cfg_i.data;
        vsaf_pkg::CFG_MAX_LOW_QUAL_FRAC: lq_frac_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign out_adv = s1_valid_q && (!out_valid_q || out_o.ready);
  assign s1_load = valid_i && (!s1_valid_q || out_adv);
  assign pop_o   = s1_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_load) begin
      s1_valid_q <= 1'b1;
    end else if (out_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      p_min_q     <= PW'(min_frac_q) * PW'(rec_i.depth);
      p_max_q     <= PW'(max_frac_q) * PW'(rec_i.depth);
      p_lq_q      <= LW'(lq_frac_q) * LW'(rec_i.lq_sum);
      depth_lt_q  <= rec_i.depth < min_depth_q;
      chunk_end_q <= rec_i.chunk_end;
      low_q       <= rec_i.low;
      top_q       <= rec_i.top;
      second_q    <= rec_i.second;
    end
  end

  assign top_sc    = PW'({top_q, {vsaf_pkg::Q16_BITS{1'b0}}});
  assign second_sc = PW'({second_q, {vsaf_pkg::Q16_BITS{1'b0}}});
  assign lq_fail   = LW'({low_q, {vsaf_pkg::Q16_BITS{1'b0}}}) > p_lq_q;
  assign top_ok    = !(top_sc < p_min_q) && !(top_sc > p_max_q);
  assign second_ok = !(second_sc < p_min_q) && !(second_sc > p_max_q);
  assign keep      = !depth_lt_q && !lq_fail && top_ok && second_ok;
  assign idx_sat   = (kept_cnt_q > KW'(MAX_SITES - 1)) ? KW'(MAX_SITES - 1) : kept_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      kept_cnt_q  <= '0;
    end else begin
      if (out_adv) begin
        out_valid_q <= 1'b1;
        if (chunk_end_q) begin
          kept_cnt_q <= '0;
        end else if (keep && kept_cnt_q != KW'(MAX_SITES)) begin
          kept_cnt_q <= kept_cnt_q + 1'b1;
        end
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv) begin
      keep_q    <= keep;
      idx_q     <= keep ? vsaf_pkg::IDX_W'(idx_sat) : '0;
      otop_q    <= top_q;
      osecond_q <= second_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.keep       = keep_q;
  assign out_o.kept_index = idx_q;
  assign out_o.top_cov    = otop_q;
  assign out_o.second_cov = osecond_q;

  a_reject_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !keep_q) |-> (idx_q == '0))
    else $error("rejected site carries nonzero index");

  a_kept_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_cnt_q <= KW'(MAX_SITES))
    else $error("kept counter beyond limit");

endmodule
`default_nettype wire

// ----- sv/variant_site_allele_filter_top.sv -----
// Top level: variant site allele filter, front, site queue and back.
//
//  channel  dir  handshake        beat
//  in_i     in   valid / ready    one allele entry of a site
//  out_o    out  valid / ready    one judged site (keep, kept index, top two coverages)
//  cfg_i    in   valid / ready    one register write, index and data
//
//  One allele entry per cycle while in_i.ready is high; the front updates the top-two
//  registers as each entry is taken. A site result goes from the queue write on the
//  edge that takes its last entry to the product stage, then the result register.
//  Reset clears the top-two registers, queue, stages and kept counter.
//  A stall on out_o fills the back stages, then the four-entry site queue, then
//  drops in_i.ready; entries of an unfinished site still need a free queue slot.
`default_nettype none
module variant_site_allele_filter_top #(
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned MAX_SITES  = 1048576
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  vsaf_in_if.sink    in_i,
  vsaf_out_if.source out_o,
  vsaf_cfg_if.sink   cfg_i
);

  vsaf_pkg::site_rec_t push_rec, head_rec;
  logic                push, full, head_valid, pop;

  vsaf_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .rec_o  (push_rec),
    .push_o (push)
  );

  vsaf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (push_rec),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .rec_o   (head_rec)
  );

  vsaf_back #(
    .MAX_SITES(MAX_SITES)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_i),
    .valid_i (head_valid),
    .rec_i   (head_rec),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
`default_nettype wire
